// ===== sv/rvod_pkg.sv =====
package rvod_pkg;

  // cell layout and sizes
  localparam int unsigned CellCount  = 8;
  localparam int unsigned CellW      = 32;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned GreenLsb   = 8;
  localparam int unsigned BlueLsb    = 16;
  localparam int unsigned AlphaLsb   = 24;
  localparam int unsigned WeightW    = ChanW + 1;
  localparam int unsigned ProdW      = ChanW + WeightW;
  localparam int unsigned SumW       = 19;
  localparam int unsigned TotalW     = 12;
  localparam int unsigned AlphaSumW  = 11;
  localparam int unsigned AlphaShift = 3;
  localparam int unsigned QuoW       = ChanW;
  localparam int unsigned RemW       = TotalW + QuoW;

  typedef logic [CellW-1:0] cell_t;

  // one cell after weighting
  typedef struct packed {
    logic [ProdW-1:0]   prod_r;
    logic [ProdW-1:0]   prod_g;
    logic [ProdW-1:0]   prod_b;
    logic [WeightW-1:0] weight;
    logic [ChanW-1:0]   alpha;
    logic               present;
  } lane_t;

  // per-octet totals passed from front to back
  typedef struct packed {
    logic [SumW-1:0]   sum_r;
    logic [SumW-1:0]   sum_g;
    logic [SumW-1:0]   sum_b;
    logic [TotalW-1:0] total_w;
    logic [ChanW-1:0]  alpha;
    logic              present;
  } front_res_t;

  // divider pipeline stage contents
  typedef struct packed {
    logic [RemW-1:0]   rem_r;
    logic [RemW-1:0]   rem_g;
    logic [RemW-1:0]   rem_b;
    logic [QuoW-1:0]   quo_r;
    logic [QuoW-1:0]   quo_g;
    logic [QuoW-1:0]   quo_b;
    logic [TotalW-1:0] total_w;
    logic [ChanW-1:0]  alpha;
    logic              present;
  } div_stage_t;

endpackage

// ===== sv/rvod_front.sv =====
module rvod_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_vld_i,
  output logic                in_rdy_o,
  input  rvod_pkg::cell_t     cells_i [rvod_pkg::CellCount],
  output logic                out_vld_o,
  input  logic                out_rdy_i,
  output rvod_pkg::front_res_t out_o
);

  rvod_pkg::lane_t      lane_d [rvod_pkg::CellCount];
  rvod_pkg::lane_t      lane_q [rvod_pkg::CellCount];
  logic                 lane_vld_q;
  rvod_pkg::front_res_t res_d;
  rvod_pkg::front_res_t res_q;
  logic                 res_vld_q;
  logic                 lane_rdy;
  logic                 res_rdy;

  // pipeline handshake
  assign res_rdy  = ~res_vld_q | out_rdy_i;
  assign lane_rdy = ~lane_vld_q | res_rdy;
  assign in_rdy_o = lane_rdy;

  // classify each cell and form its weighted channels
  always_comb begin
    for (int i = 0; i < int'(rvod_pkg::CellCount); i++) begin
      logic [rvod_pkg::ChanW-1:0]   a;
      logic [rvod_pkg::WeightW-1:0] w;
      logic                         pres;
      pres = (cells_i[i] != '0);
      a    = cells_i[i][rvod_pkg::AlphaLsb +: rvod_pkg::ChanW];
      w    = pres ? (rvod_pkg::WeightW'(a) + rvod_pkg::WeightW'(1)) : '0;
      lane_d[i].prod_r  = rvod_pkg::ProdW'(cells_i[i][0 +: rvod_pkg::ChanW])
                          * rvod_pkg::ProdW'(w);
      lane_d[i].prod_g  = rvod_pkg::ProdW'(cells_i[i][rvod_pkg::GreenLsb +: rvod_pkg::ChanW])
                          * rvod_pkg::ProdW'(w);
      lane_d[i].prod_b  = rvod_pkg::ProdW'(cells_i[i][rvod_pkg::BlueLsb +: rvod_pkg::ChanW])
                          * rvod_pkg::ProdW'(w);
      lane_d[i].weight  = w;
      lane_d[i].alpha   = pres ? a : '0;
      lane_d[i].present = pres;
    end
  end

  // accumulate the lanes into octet totals with the alpha floor
  always_comb begin
    logic [rvod_pkg::SumW-1:0]      sr;
    logic [rvod_pkg::SumW-1:0]      sg;
    logic [rvod_pkg::SumW-1:0]      sb;
    logic [rvod_pkg::TotalW-1:0]    tw;
    logic [rvod_pkg::AlphaSumW-1:0] asum;
    logic                           any;
    logic [rvod_pkg::ChanW-1:0]     avg;
    sr   = '0;
    sg   = '0;
    sb   = '0;
    tw   = '0;
    asum = '0;
    any  = 1'b0;
    for (int i = 0; i < int'(rvod_pkg::CellCount); i++) begin
      sr   = sr + rvod_pkg::SumW'(lane_q[i].prod_r);
      sg   = sg + rvod_pkg::SumW'(lane_q[i].prod_g);
      sb   = sb + rvod_pkg::SumW'(lane_q[i].prod_b);
      tw   = tw + rvod_pkg::TotalW'(lane_q[i].weight);
      asum = asum + rvod_pkg::AlphaSumW'(lane_q[i].alpha);
      any  = any | lane_q[i].present;
    end
    avg = rvod_pkg::ChanW'(asum >> rvod_pkg::AlphaShift);
    if (any && (avg == '0)) begin
      avg = rvod_pkg::ChanW'(1);
    end
    res_d.sum_r   = sr;
    res_d.sum_g   = sg;
    res_d.sum_b   = sb;
    res_d.total_w = tw;
    res_d.alpha   = avg;
    res_d.present = any;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (lane_rdy) begin
        lane_vld_q <= in_vld_i;
      end
      if (res_rdy) begin
        res_vld_q <= lane_vld_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (lane_rdy && in_vld_i) begin
      lane_q <= lane_d;
    end
    if (res_rdy && lane_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_vld_o = res_vld_q;
  assign out_o     = res_q;

endmodule

// ===== sv/rvod_queue.sv =====
module rvod_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_vld_i,
  output logic                 push_rdy_o,
  input  rvod_pkg::front_res_t push_data_i,
  output logic                 pop_vld_o,
  input  logic                 pop_rdy_i,
  output rvod_pkg::front_res_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rvod_pkg::front_res_t mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q;
  logic [PtrW-1:0]      rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 push;
  logic                 pop;

  assign push_rdy_o = (cnt_q != CntW'(Depth));
  assign pop_vld_o  = (cnt_q != '0);
  assign push       = push_vld_i & push_rdy_o;
  assign pop        = pop_vld_o & pop_rdy_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/rvod_back.sv =====
module rvod_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_vld_i,
  output logic                 in_rdy_o,
  input  rvod_pkg::front_res_t in_i,
  output logic                 out_vld_o,
  input  logic                 out_rdy_i,
  output rvod_pkg::cell_t      folded_cell_o,
  output logic                 any_present_o
);

  localparam int unsigned Steps = rvod_pkg::QuoW;

  rvod_pkg::div_stage_t stg_in [Steps];
  rvod_pkg::div_stage_t stg_d  [Steps];
  rvod_pkg::div_stage_t stg_q  [Steps];
  logic [Steps-1:0]     vld_in;
  logic [Steps-1:0]     vld_q;
  logic [Steps:0]       rdy;

  // ready ripples back from the output
  always_comb begin
    rdy[Steps] = out_rdy_i;
    for (int s = Steps - 1; s >= 0; s--) begin
      rdy[s] = ~vld_q[s] | rdy[s+1];
    end
  end
  assign in_rdy_o = rdy[0];

  // load the queue head into the first divide step
  always_comb begin
    stg_in[0].rem_r   = rvod_pkg::RemW'(in_i.sum_r);
    stg_in[0].rem_g   = rvod_pkg::RemW'(in_i.sum_g);
    stg_in[0].rem_b   = rvod_pkg::RemW'(in_i.sum_b);
    stg_in[0].quo_r   = '0;
    stg_in[0].quo_g   = '0;
    stg_in[0].quo_b   = '0;
    stg_in[0].total_w = in_i.total_w;
    stg_in[0].alpha   = in_i.alpha;
    stg_in[0].present = in_i.present;
    vld_in[0]         = in_vld_i;
  end

  // one restoring quotient bit per stage, msb first
  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int unsigned Shift = Steps - 1 - s;

    logic [rvod_pkg::RemW-1:0] dsh;
    logic                      ge_r;
    logic                      ge_g;
    logic                      ge_b;

    if (s > 0) begin : g_link
      assign stg_in[s] = stg_q[s-1];
      assign vld_in[s] = vld_q[s-1];
    end

    assign dsh  = rvod_pkg::RemW'(stg_in[s].total_w) << Shift;
    assign ge_r = (stg_in[s].rem_r >= dsh);
    assign ge_g = (stg_in[s].rem_g >= dsh);
    assign ge_b = (stg_in[s].rem_b >= dsh);

    always_comb begin
      stg_d[s]       = stg_in[s];
      stg_d[s].rem_r = ge_r ? stg_in[s].rem_r - dsh : stg_in[s].rem_r;
      stg_d[s].rem_g = ge_g ? stg_in[s].rem_g - dsh : stg_in[s].rem_g;
      stg_d[s].rem_b = ge_b ? stg_in[s].rem_b - dsh : stg_in[s].rem_b;
      stg_d[s].quo_r = {stg_in[s].quo_r[rvod_pkg::QuoW-2:0], ge_r};
      stg_d[s].quo_g = {stg_in[s].quo_g[rvod_pkg::QuoW-2:0], ge_g};
      stg_d[s].quo_b = {stg_in[s].quo_b[rvod_pkg::QuoW-2:0], ge_b};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vld_in[s]) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  // pack the result, empty octets fold to zero
  assign out_vld_o     = vld_q[Steps-1];
  assign any_present_o = stg_q[Steps-1].present;
  assign folded_cell_o = stg_q[Steps-1].present
                         ? {stg_q[Steps-1].alpha, stg_q[Steps-1].quo_b,
                            stg_q[Steps-1].quo_g, stg_q[Steps-1].quo_r}
                         : '0;

endmodule

// ===== sv/rgba_voxel_octet_downsample.sv =====
// Folds a 2x2x2 octet of packed RGBA cells (red 7:0, green 15:8, blue 23:16,
// alpha 31:24) into one cell. A cell of exactly zero is empty and skipped; every
// other cell weighs alpha+1. Red, green and blue are the truncated weighted
// averages, alpha is the summed alpha over eight, raised to one if it is zero
// while any cell is present. An all-empty octet gives zero with any_present_o
// low. One octet is taken per cycle and one result leaves per cycle when
// nothing stalls. Each octet passes two front stages (per-cell weighting, then
// the summing tree), the queue, and eight stages of the pipelined restoring
// divider that produce one quotient bit each. QueueDepth sets how many summed
// octets can wait between front and divider.
module rgba_voxel_octet_downsample #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] cell_0_i,
  input  logic [31:0] cell_1_i,
  input  logic [31:0] cell_2_i,
  input  logic [31:0] cell_3_i,
  input  logic [31:0] cell_4_i,
  input  logic [31:0] cell_5_i,
  input  logic [31:0] cell_6_i,
  input  logic [31:0] cell_7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] folded_cell_o,
  output logic        any_present_o
);

  rvod_pkg::cell_t      cells [rvod_pkg::CellCount];
  logic                 front_rdy;
  logic                 front_vld;
  logic                 queue_push_rdy;
  rvod_pkg::front_res_t front_res;
  logic                 queue_vld;
  logic                 back_rdy;
  rvod_pkg::front_res_t queue_head;

  // gather the cell ports
  assign cells[0] = cell_0_i;
  assign cells[1] = cell_1_i;
  assign cells[2] = cell_2_i;
  assign cells[3] = cell_3_i;
  assign cells[4] = cell_4_i;
  assign cells[5] = cell_5_i;
  assign cells[6] = cell_6_i;
  assign cells[7] = cell_7_i;

  assign in_stall_o = ~front_rdy;

  // weighting and summing
  rvod_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (in_valid_i),
    .in_rdy_o  (front_rdy),
    .cells_i   (cells),
    .out_vld_o (front_vld),
    .out_rdy_i (queue_push_rdy),
    .out_o     (front_res)
  );

  // decoupling queue
  rvod_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (front_vld),
    .push_rdy_o  (queue_push_rdy),
    .push_data_i (front_res),
    .pop_vld_o   (queue_vld),
    .pop_rdy_i   (back_rdy),
    .pop_data_o  (queue_head)
  );

  // division and packing
  rvod_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_vld_i      (queue_vld),
    .in_rdy_o      (back_rdy),
    .in_i          (queue_head),
    .out_vld_o     (out_valid_o),
    .out_rdy_i     (~out_stall_i),
    .folded_cell_o (folded_cell_o),
    .any_present_o (any_present_o)
  );

endmodule
